FILE: rtl/llcl_pkg.sv
// Package: shared types and constants of the LRU line cache lookup block.
`timescale 1ns / 1ps
package llcl_pkg;

   localparam int ADDR_W       = 64;
   localparam int LSL_W        = 4;
   localparam int CAP_W        = 7;
   localparam int CSR_IDX_W    = 4;
   localparam int CSR_DATA_W   = 7;
   localparam int LINE_LOG2_MAX = 12;

   localparam logic [LSL_W-1:0] LSL_RESET = 4'd6;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_SIZE_LOG2 = 4'd0,
      CSR_CAPACITY       = 4'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE
   } state_type;

   // control from the sequencer to every cell
   typedef struct packed {
      logic sample;
      logic update;
   } llcl_ctl_type;

   // what one cell hands to the next
   typedef struct packed {
      logic     valid;
      addr_type tag;
   } llcl_link_type;

endpackage

FILE: rtl/llcl_req_if.sv
// Interface: request channel carrying one byte address per item.
`timescale 1ns / 1ps
interface llcl_req_if;
   import llcl_pkg::*;
   logic     valid;
   logic     ready;
   addr_type byte_address;
   modport source (output valid, output byte_address, input ready);
   modport sink (input valid, input byte_address, output ready);
endinterface

FILE: rtl/llcl_rsp_if.sv
// Interface: response channel carrying hit flag and line address per item.
`timescale 1ns / 1ps
interface llcl_rsp_if;
   import llcl_pkg::*;
   logic     valid;
   logic     ready;
   logic     hit;
   addr_type line_address;
   modport source (output valid, output hit, output line_address, input ready);
   modport sink (input valid, input hit, input line_address, output ready);
endinterface

FILE: rtl/llcl_csr_if.sv
// Interface: register write channel carrying an index and write data.
`timescale 1ns / 1ps
interface llcl_csr_if;
   import llcl_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/llcl_cell.sv
// Cell: one recency position of the LRU stack, tag compare and shift from neighbor.
`timescale 1ns / 1ps
module llcl_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  llcl_pkg::llcl_ctl_type ctl,
   input  logic                   shift,
   input  llcl_pkg::addr_type     line,
   input  llcl_pkg::llcl_link_type prev,
   output llcl_pkg::llcl_link_type cur,
   output logic                   match
);
   import llcl_pkg::*;

   logic     valid_ff, valid_in;
   addr_type tag_ff, tag_in;
   logic     match_ff, match_in;

   always_comb begin
      valid_in = valid_ff;
      tag_in   = tag_ff;
      if (ctl.update && shift) begin
         valid_in = prev.valid;
         tag_in   = prev.tag;
      end
      match_in = ctl.sample ? (valid_ff && (tag_ff == line)) : match_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   assign cur.valid = valid_ff;
   assign cur.tag   = tag_ff;
   assign match     = match_ff;

endmodule

FILE: rtl/lru_line_cache_lookup_top.sv
// Top level: fully associative LRU line cache lookup built as a row of stack cells.
//
//  channel  dir  handshake      payload
//  req_port in   valid/ready    byte_address[63:0]
//  rsp_port out  valid/ready    hit, line_address[63:0]
//  csr_port in   valid/ready    index[3:0], data[6:0]
//
// Per item: a registered tag compare in every cell, then one shift of the cell row
// moving the accessed line to the head (MRU at cell 0) and taking the next item.
// Reset empties the cache; no clearing pass.
// A result not yet taken holds the update step and the next item waits.
// csr_port is always ready.
`timescale 1ns / 1ps
module lru_line_cache_lookup_top #(
   parameter int ENTRIES = 64
) (
   input logic clock,
   input logic reset,
   llcl_req_if.sink   req_port,
   llcl_rsp_if.source rsp_port,
   llcl_csr_if.sink   csr_port
);
   import llcl_pkg::*;

   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   state_type state_ff, state_in;
   llcl_ctl_type ctl;

   logic [LSL_W-1:0] lsl_ff;
   logic [CAP_W-1:0] cap_ff;
   logic [CNT_W-1:0] occ_ff, occ_in;
   addr_type         line_ff;
   addr_type         aligned;
   logic [LSL_W-1:0] shamt;

   logic             rsp_valid_ff;
   logic             rsp_hit_ff;
   addr_type         rsp_line_ff;
   logic             out_free;
   logic             req_take;

   llcl_link_type    link [ENTRIES+1];
   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] shift;
   logic             hit;
   logic             evict;
   logic [CMP_W-1:0] cap_ext, eff_cap, occ_ext;
   logic [CNT_W-1:0] limit;

   // configuration
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lsl_ff <= LSL_RESET;
         cap_ff <= CAP_RESET;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            CSR_LINE_SIZE_LOG2: lsl_ff <= csr_port.data[LSL_W-1:0];
            CSR_CAPACITY:       cap_ff <= csr_port.data[CAP_W-1:0];
            default:            ;
         endcase
      end
   end

   // line alignment
   assign shamt   = (lsl_ff > LSL_W'(LINE_LOG2_MAX)) ? LSL_W'(LINE_LOG2_MAX) : lsl_ff;
   assign aligned = req_port.byte_address & ~((ADDR_W'(1) << shamt) - ADDR_W'(1));

   // sequencer
   assign out_free = !rsp_valid_ff || rsp_port.ready;

   always_comb begin
      state_in       = state_ff;
      req_port.ready = 1'b0;
      ctl.sample     = 1'b0;
      ctl.update     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_port.ready = 1'b1;
            if (req_port.valid) state_in = ST_MATCH;
         end
         ST_MATCH: begin
            ctl.sample = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               ctl.update     = 1'b1;
               req_port.ready = 1'b1;
               state_in       = req_port.valid ? ST_MATCH : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_take = req_port.valid && req_port.ready;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (req_take) line_ff <= aligned;
   end

   // replacement decision
   assign hit     = |match;
   assign cap_ext = CMP_W'(cap_ff);
   assign occ_ext = CMP_W'(occ_ff);
   assign eff_cap = (cap_ext == '0) ? CMP_W'(1) :
                    (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
   assign evict   = !hit && (occ_ext >= eff_cap);
   assign limit   = occ_ff + CNT_W'(!evict);

   always_comb begin
      occ_in = occ_ff;
      if (ctl.update && !hit && !evict) occ_in = occ_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) occ_ff <= '0;
      else       occ_ff <= occ_in;
   end

   // cell row: the head takes the current line
   assign link[0].valid = 1'b1;
   assign link[0].tag   = line_ff;

   assign shift[0] = 1'b1;

   for (genvar j = 1; j < ENTRIES; j++) begin : g_shift
      assign shift[j] = hit ? !(|match[j-1:0]) : (CNT_W'(j) < limit);
   end

   for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
      llcl_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .shift (shift[j]),
         .line  (line_ff),
         .prev  (link[j]),
         .cur   (link[j+1]),
         .match (match[j])
      );
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.update) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.update) begin
         rsp_hit_ff  <= hit;
         rsp_line_ff <= line_ff;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.hit          = rsp_hit_ff;
   assign rsp_port.line_address = rsp_line_ff;

endmodule
